/* hw/rtl/quadrature_position_speed_defines.svh */
// assertion macros for the quadrature position and speed block
`ifndef QUADRATURE_POSITION_SPEED_DEFINES_SVH
`define QUADRATURE_POSITION_SPEED_DEFINES_SVH

// same-cycle implication, checked outside reset
`define QPS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define QPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/qps_pkg.sv */
package qps_pkg;

  localparam int COUNT_WIDTH = 32;
  localparam int IV_W = 20;
  localparam int MAG_W = 32;
  localparam int PROD_W = MAG_W + IV_W;
  localparam int QUO_W = 33;
  localparam int HI_W = PROD_W - QUO_W;
  localparam int REM_W = IV_W + 1;
  localparam int STEP_CNT_W = $clog2(QUO_W + 1);
  localparam logic [IV_W-1:0] IV_RESET = IV_W'(10000);
  localparam logic [IV_W-1:0] SPEED_SCALE = IV_W'(1000000);
  localparam logic [31:0] SPEED_MAX = 32'h7fff_ffff;
  localparam logic [31:0] SPEED_MIN = 32'h8000_0000;

  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_TICK   = 2'd1,
    CMD_SET    = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STEP_NONE,
    STEP_UP,
    STEP_DOWN
  } step_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MULTIPLY,
    ST_LOAD,
    ST_DIVIDE,
    ST_SATURATE,
    ST_PUBLISH
  } state_t;

  typedef struct packed {
    cmd_t               command;
    logic               pin_a;
    logic               pin_b;
    logic signed [31:0] new_position;
  } qps_in_t;

  typedef struct packed {
    logic signed [31:0] live_count;
    logic signed [31:0] position;
    logic signed [31:0] speed;
  } qps_out_t;

  typedef struct packed {
    logic take_sample;
    logic take_tick;
    logic take_set;
    logic mult;
    logic load;
    logic div_step;
    logic saturate;
    logic publish;
  } ctl_t;

  typedef struct packed {
    logic div_last;
    logic slot_free;
  } sts_t;

  // transition code is {previous a, previous b, a, b}
  function automatic step_t qps_step(input logic [3:0] code);
    step_t s;
    unique case (code)
      4'b1101, 4'b0100, 4'b0010, 4'b1011: s = STEP_UP;
      4'b1110, 4'b0111, 4'b0001, 4'b1000: s = STEP_DOWN;
      default:                            s = STEP_NONE;
    endcase
    return s;
  endfunction

endpackage

/* hw/rtl/qps_datapath.sv */
module qps_datapath
  import qps_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [IV_W-1:0] cfg_wdata,
  input  qps_in_t         in_data,
  input  ctl_t            ctl,
  output sts_t            sts,
  input  logic            out_ready,
  output logic            out_valid,
  output qps_out_t        out_data
);

  logic [IV_W-1:0]        iv;
  logic [1:0]             pair;
  logic [COUNT_WIDTH-1:0] count;
  logic [COUNT_WIDTH-1:0] prev;
  logic [COUNT_WIDTH-1:0] pos;
  logic [31:0]            speed;

  logic [MAG_W-1:0]       mag32;
  logic                   mag_ovf;
  logic                   neg;
  logic [PROD_W-1:0]      product;
  logic [REM_W-1:0]       rem;
  logic [QUO_W-1:0]       quo;
  logic                   ovf;
  logic [STEP_CNT_W-1:0]  step_cnt;

  logic [IV_W-1:0]        iv_eff;
  logic [COUNT_WIDTH-1:0] delta;
  logic [COUNT_WIDTH-1:0] mag;
  logic [63:0]            mag_wide;
  logic [HI_W-1:0]        prod_hi;
  logic [REM_W-1:0]       trial;
  logic                   trial_ge;
  logic                   q_big;
  logic [31:0]            speed_next;
  step_t                  step;
  logic [COUNT_WIDTH-1:0] set_value;

  assign iv_eff    = (iv == '0) ? IV_W'(1) : iv;
  assign delta     = count - prev;
  assign mag       = delta[COUNT_WIDTH-1] ? (~delta + COUNT_WIDTH'(1)) : delta;
  assign mag_wide  = 64'(mag);
  assign prod_hi   = product[PROD_W-1 -: HI_W];
  assign trial     = {rem[REM_W-2:0], quo[QUO_W-1]};
  assign trial_ge  = trial >= REM_W'(iv_eff);
  assign q_big     = |quo[QUO_W-1:31];
  assign step      = qps_step({pair, in_data.pin_a, in_data.pin_b});
  assign set_value = COUNT_WIDTH'(in_data.new_position);

  always_comb begin
    if (ovf || q_big) begin
      speed_next = neg ? SPEED_MIN : SPEED_MAX;
    end else if (neg) begin
      speed_next = ~quo[31:0] + 32'd1;
    end else begin
      speed_next = quo[31:0];
    end
  end

  assign sts.div_last  = step_cnt == STEP_CNT_W'(1);
  assign sts.slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      iv    <= IV_RESET;
      pair  <= '0;
      count <= '0;
      prev  <= '0;
      pos   <= '0;
      speed <= '0;
    end else begin
      if (cfg_we) begin
        iv <= cfg_wdata;
      end
      if (ctl.take_sample) begin
        pair <= {in_data.pin_a, in_data.pin_b};
        unique case (step)
          STEP_UP:   count <= count + COUNT_WIDTH'(1);
          STEP_DOWN: count <= count - COUNT_WIDTH'(1);
          default:   count <= count;
        endcase
      end
      if (ctl.take_tick) begin
        pos  <= count;
        prev <= count;
      end
      if (ctl.take_set) begin
        count <= set_value;
        prev  <= set_value;
        pos   <= set_value;
      end
      if (ctl.saturate) begin
        speed <= speed_next;
      end
    end
  end

  // speed arithmetic
  always_ff @(posedge clk) begin
    if (ctl.take_tick) begin
      mag32   <= mag_wide[MAG_W-1:0];
      mag_ovf <= |mag_wide[63:MAG_W];
      neg     <= delta[COUNT_WIDTH-1];
    end
    if (ctl.mult) begin
      product <= PROD_W'(mag32) * PROD_W'(SPEED_SCALE);
    end
    if (ctl.load) begin
      rem      <= REM_W'(prod_hi);
      quo      <= product[QUO_W-1:0];
      ovf      <= mag_ovf || (REM_W'(prod_hi) >= REM_W'(iv_eff));
      step_cnt <= STEP_CNT_W'(QUO_W);
    end
    if (ctl.div_step) begin
      rem      <= trial_ge ? (trial - REM_W'(iv_eff)) : trial;
      quo      <= {quo[QUO_W-2:0], trial_ge};
      step_cnt <= step_cnt - STEP_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.publish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.publish) begin
      out_data.live_count <= 32'($signed(count));
      out_data.position   <= 32'($signed(pos));
      out_data.speed      <= speed;
    end
  end

endmodule

/* hw/rtl/qps_controller.sv */
`include "quadrature_position_speed_defines.svh"

module qps_controller
  import qps_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  cmd_t command,
  input  sts_t sts,
  output logic in_ready,
  output ctl_t ctl
);

  state_t state;
  state_t state_next;
  logic   take;

  assign take = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = (command == CMD_TICK) ? ST_MULTIPLY : ST_PUBLISH;
        end
      end
      ST_MULTIPLY: state_next = ST_LOAD;
      ST_LOAD:     state_next = ST_DIVIDE;
      ST_DIVIDE: begin
        if (sts.div_last) begin
          state_next = ST_SATURATE;
        end
      end
      ST_SATURATE: state_next = ST_PUBLISH;
      ST_PUBLISH: begin
        if (sts.slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready        = state == ST_IDLE;
    ctl             = '0;
    ctl.take_sample = take && (command == CMD_SAMPLE);
    ctl.take_tick   = take && (command == CMD_TICK);
    ctl.take_set    = take && (command == CMD_SET);
    ctl.mult        = state == ST_MULTIPLY;
    ctl.load        = state == ST_LOAD;
    ctl.div_step    = state == ST_DIVIDE;
    ctl.saturate    = state == ST_SATURATE;
    ctl.publish     = (state == ST_PUBLISH) && sts.slot_free;
  end

  `QPS_ASSERT_NEXT(a_tick_starts_mult, ctl.take_tick, state == ST_MULTIPLY, "tick request did not start the multiply")
  `QPS_ASSERT_NEXT(a_div_ends, ctl.div_step && sts.div_last, state == ST_SATURATE, "divide did not end after its last step")
  `QPS_ASSERT_NOW(a_publish_free, ctl.publish, sts.slot_free, "result written over an untaken one")

endmodule

/* hw/rtl/quadrature_position_speed.sv */
// 4x quadrature decoder with position latch and speed. Each request is a pin sample, a timer
// tick or a set; every request gives one result with the live count, the latched position and
// the latched speed. A pin sample, a set or an unused command goes from the accepting cycle
// straight to the result register. A tick runs through the accepting cycle, one multiply of the
// count difference by one million, a load, a restoring divide by interval_us that makes one of
// 33 quotient bits per cycle, saturation and the result write. The next request is taken once
// the result is in the output register, so a waiting result does not stall the input until the
// following one is ready. interval_us of zero acts as one and may be written only while no
// request is in flight.
module quadrature_position_speed
  import qps_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [IV_W-1:0] cfg_wdata,
  input  logic            in_valid,
  output logic            in_ready,
  input  qps_in_t         in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output qps_out_t        out_data
);

  ctl_t ctl;
  sts_t sts;

  qps_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .command  (in_data.command),
    .sts      (sts),
    .in_ready (in_ready),
    .ctl      (ctl)
  );

  qps_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .ctl       (ctl),
    .sts       (sts),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
